/* hw/rtl/bea_pkg.sv */
// Shared types and constants of the bitmap extent allocator.
`timescale 1ns / 1ps
`default_nettype none

package bea_pkg;

  localparam int WORD_W  = 32;
  localparam int WORD_LW = 5;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_RESERVE = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               hit;
    logic [WORD_LW-1:0] pos;
  } scan_res_t;

endpackage

`default_nettype wire

/* hw/rtl/bea_map_mem.sv */
// Word-wide used map storage with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bea_map_mem
  import bea_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [WORD_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bea_word_scan.sv */
// Free-run search over one map word, continuing the run carried in from lower words.
`timescale 1ns / 1ps
`default_nettype none

module bea_word_scan
  import bea_pkg::*;
#(
  parameter int CW = 12
) (
  input  wire logic [WORD_W-1:0] word,
  input  wire logic [CW-1:0]     run_in,
  input  wire logic [CW-1:0]     len,
  output scan_res_t              res,
  output logic      [CW-1:0]     run_out
);

  logic [WORD_W-1:0]  v;
  logic [WORD_W-1:0]  v_n;
  logic [WORD_LW-1:0] idx   [WORD_W];
  logic [WORD_LW-1:0] idx_n [WORD_W];
  logic [CW-1:0]      run_end [WORD_W];
  logic [WORD_W-1:0]  hit;

  // Parallel prefix: for each bit, the position of the nearest used bit at or below it.
  always_comb begin
    v = word;
    for (int j = 0; j < WORD_W; j++) begin
      idx[j] = WORD_LW'(j);
    end
    for (int l = 0; l < WORD_LW; l++) begin
      v_n = v;
      for (int j = 0; j < WORD_W; j++) begin
        idx_n[j] = idx[j];
        if (!v[j] && j >= (1 << l)) begin
          v_n[j]   = v[j - (1 << l)];
          idx_n[j] = idx[j - (1 << l)];
        end
      end
      v = v_n;
      for (int j = 0; j < WORD_W; j++) begin
        idx[j] = idx_n[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      if (v[j]) begin
        run_end[j] = CW'(WORD_LW'(j) - idx[j]);
      end else begin
        run_end[j] = run_in + CW'(j) + CW'(1);
      end
      hit[j] = (run_end[j] >= len);
    end
  end

  always_comb begin
    res.hit = |hit;
    res.pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        res.pos = WORD_LW'(j);
      end
    end
    if (v[WORD_W-1]) begin
      run_out = CW'(WORD_LW'(WORD_W - 1) - idx[WORD_W-1]);
    end else begin
      run_out = run_in + CW'(WORD_W);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bitmap_extent_allocator.sv */
// First-fit contiguous bitmap allocator: top level with control sequencer.
//
// A request transaction (kind, first_block, count) is taken on req_valid with
// req_stall low; exactly one response transaction (status, granted_block)
// follows on rsp_valid, taken when rsp_stall is low. One request is in work
// at a time. The used map sits in a memory of 32-bit words, POOL_BLOCKS/32
// words deep (rounded up), read one word per cycle.
// Allocate scans words from the bottom, one word per cycle, until the run is
// found, then marks the run with a read-modify-write of each word it touches,
// one word per cycle after the registered read of the first word. Free and
// reserve take the same marking pass only. The response is registered from
// the done state once the response register is free.
// The response register frees the request side: a new request is taken
// while an earlier response still waits under rsp_stall, but its own result
// waits until that register is empty.
// After reset the map is cleared by a pass that writes every word, during
// which req_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_extent_allocator
  import bea_pkg::*;
#(
  parameter int POOL_BLOCKS = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] kind,
  input  wire logic [9:0] first_block,
  input  wire logic [10:0] count,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic            status,
  output logic [9:0]      granted_block
);

  localparam int LOG       = $clog2(POOL_BLOCKS);
  localparam int IW        = (LOG + 2 > 12) ? LOG + 2 : 12;
  localparam int NUM_WORDS = (POOL_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WAW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int TAIL      = POOL_BLOCKS - (NUM_WORDS - 1) * WORD_W;
  localparam logic [WAW-1:0]    LAST_WORD = WAW'(NUM_WORDS - 1);
  localparam logic [IW-1:0]     NB        = IW'(POOL_BLOCKS);
  localparam logic [WORD_W-1:0] TAIL_FREE = {WORD_W{1'b1}} >> (WORD_W - TAIL);

  state_t state;
  state_t state_next;

  logic [WAW-1:0] w;
  logic [IW-1:0]  run;
  logic [IW-1:0]  len;
  logic [IW-1:0]  mk_start;
  logic [IW-1:0]  mk_last;
  logic           mk_set;
  logic           res_status;
  logic [9:0]     res_granted;

  logic              rd_en;
  logic [WAW-1:0]    rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [WAW-1:0]    wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic              accept;
  logic              rsp_free;
  logic [IW-1:0]     req_cnt;
  logic [IW-1:0]     req_first;
  logic [IW-1:0]     req_end;
  logic [IW-1:0]     req_last;
  logic [WORD_W-1:0] scan_word;
  scan_res_t         scan_res;
  logic [IW-1:0]     scan_run_out;
  logic [IW-1:0]     hit_pos;
  logic [IW-1:0]     hit_start;
  logic [WAW-1:0]    start_word;
  logic [WAW-1:0]    last_word;
  logic [WORD_LW-1:0] lo_bit;
  logic [WORD_LW-1:0] hi_bit;
  logic [WORD_W-1:0] run_mask;

  bea_map_mem #(
    .DEPTH(NUM_WORDS),
    .AW   (WAW)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // Padding bits beyond the pool end in the top word count as used.
  assign scan_word = rd_data | ((w == LAST_WORD) ? ~TAIL_FREE : '0);

  bea_word_scan #(
    .CW(IW)
  ) u_scan (
    .word   (scan_word),
    .run_in (run),
    .len    (len),
    .res    (scan_res),
    .run_out(scan_run_out)
  );

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign req_cnt   = IW'(count);
  assign req_first = IW'(first_block);
  assign req_end   = req_first + req_cnt;
  assign req_last  = ((req_end > NB) ? NB : req_end) - IW'(1);

  assign hit_pos   = IW'({w, scan_res.pos});
  assign hit_start = hit_pos + IW'(1) - len;

  assign start_word = mk_start[WAW+WORD_LW-1:WORD_LW];
  assign last_word  = mk_last[WAW+WORD_LW-1:WORD_LW];
  assign lo_bit     = (w == start_word) ? mk_start[WORD_LW-1:0] : '0;
  assign hi_bit     = (w == last_word) ? mk_last[WORD_LW-1:0] : WORD_LW'(WORD_W - 1);
  assign run_mask   = ({WORD_W{1'b1}} << lo_bit)
                    & ({WORD_W{1'b1}} >> (WORD_LW'(WORD_W - 1) - hi_bit));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = w + WAW'(1);
    wr_en      = 1'b0;
    wr_addr    = w;
    wr_data    = '0;
    case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (w == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DONE;
          case (kind)
            KIND_ALLOC: begin
              if (req_cnt != '0 && req_cnt <= NB) begin
                state_next = ST_SCAN;
                rd_en      = 1'b1;
                rd_addr    = '0;
              end
            end
            KIND_FREE, KIND_RESERVE: begin
              if (req_cnt != '0 && req_first < NB) begin
                state_next = ST_MARK_RD;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_res.hit) begin
          state_next = ST_MARK_RD;
        end else if (w == LAST_WORD) begin
          state_next = ST_DONE;
        end else begin
          rd_en = 1'b1;
        end
      end
      ST_MARK_RD: begin
        rd_en      = 1'b1;
        rd_addr    = start_word;
        state_next = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        wr_en   = 1'b1;
        wr_data = mk_set ? (rd_data | run_mask) : (rd_data & ~run_mask);
        if (w == last_word) begin
          state_next = ST_DONE;
        end else begin
          rd_en = 1'b1;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w <= '0;
    end else begin
      case (state)
        ST_CLEAR: w <= w + WAW'(1);
        ST_SCAN, ST_MARK_WR: begin
          if (rd_en) begin
            w <= w + WAW'(1);
          end
        end
        ST_MARK_RD: w <= start_word;
        ST_IDLE: begin
          if (accept) begin
            w <= '0;
          end
        end
        default: w <= w;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          run         <= '0;
          len         <= req_cnt;
          mk_start    <= req_first;
          mk_last     <= req_last;
          mk_set      <= (kind != KIND_FREE);
          res_granted <= '0;
          res_status  <= (kind == KIND_ALLOC) && (req_cnt > NB);
        end
      end
      ST_SCAN: begin
        run <= scan_run_out;
        if (scan_res.hit) begin
          mk_start    <= hit_start;
          mk_last     <= hit_pos;
          res_granted <= hit_start[9:0];
        end else if (w == LAST_WORD) begin
          res_status <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && rsp_free) begin
      status        <= res_status;
      granted_block <= res_granted;
    end
  end

  // The marking pass never reads the word it is writing back.
  assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("map read and write hit the same word");

  // The carried free run stays short of the request, or the scan would have stopped.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (run < len))
    else $error("carried free run reached the requested length");

  // Every word written during marking lies inside the run.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK_WR) |-> (w >= start_word && w <= last_word && mk_last < NB
                               && mk_start <= mk_last))
    else $error("marking outside the run or the pool");

  // A response only appears when a request has finished its work.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_DONE))
    else $error("response without a finished request");

  // No request is taken while the map is still being cleared.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> !$past(accept))
    else $error("request taken during the clearing pass");

endmodule

`default_nettype wire

/* bench/extent_checker.sv */
// Checker for the bitmap extent allocator: shadow used map, expected responses and compare.
`timescale 1ns / 1ps

module extent_checker
  import bea_pkg::*;
#(
  parameter int POOL_BLOCKS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [1:0]  kind,
  input  logic [9:0]  first_block,
  input  logic [10:0] count,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic        status,
  input  logic [9:0]  granted_block,
  output int          fail_count,
  output int          outstanding
);

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_RUN = 1'b1;

  typedef struct {
    logic       status;
    logic [9:0] granted_block;
  } alloc_rsp_t;

  bit         block_used[POOL_BLOCKS];
  alloc_rsp_t expected_rsp_q[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Runs are clipped at the end of the pool; a start past the end touches nothing.
  function automatic void set_blocks(int unsigned start, int unsigned len, bit val);
    int unsigned stop;
    if (start >= POOL_BLOCKS) return;
    stop = start + len;
    if (stop > POOL_BLOCKS) stop = POOL_BLOCKS;
    for (int unsigned b = start; b < stop; b++) block_used[b] = val;
  endfunction

  // Applies one request to the shadow map and returns the response it must produce.
  function automatic alloc_rsp_t serve_request(logic [1:0] k, logic [9:0] fb,
                                               logic [10:0] cnt);
    alloc_rsp_t  rsp;
    int unsigned run;
    int unsigned found_at;
    bit          found;
    rsp.status        = STATUS_OK;
    rsp.granted_block = '0;
    run      = 0;
    found_at = 0;
    found    = 1'b0;
    case (k)
      KIND_ALLOC: begin
        if (cnt == 0) begin
          found = 1'b1;
        end else if (cnt <= POOL_BLOCKS) begin
          for (int b = 0; b < POOL_BLOCKS && !found; b++) begin
            if (block_used[b]) begin
              run = 0;
            end else begin
              run++;
              if (run == cnt) begin
                found    = 1'b1;
                found_at = b + 1 - cnt;
              end
            end
          end
        end
        if (found) begin
          set_blocks(found_at, cnt, 1'b1);
          rsp.granted_block = found_at[9:0];
        end else begin
          rsp.status = STATUS_NO_RUN;
        end
      end
      KIND_FREE:    set_blocks(fb, cnt, 1'b0);
      KIND_RESERVE: set_blocks(fb, cnt, 1'b1);
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk) begin : watch
    alloc_rsp_t want;
    if (rst) begin
      foreach (block_used[i]) block_used[i] = 1'b0;
      expected_rsp_q.delete();
    end else begin
      // Responses are handled before requests so that one accepted on the same edge
      // as a request can only match an earlier transaction.
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch($sformatf("response with none expected (status %0d, block %0d)",
                                    status, granted_block));
        end else begin
          want = expected_rsp_q.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status mismatch: expected %0d, got %0d",
                                      want.status, status));
          if (granted_block !== want.granted_block)
            report_mismatch($sformatf("granted_block mismatch: expected %0d, got %0d",
                                      want.granted_block, granted_block));
        end
      end
      if (req_valid && !req_stall)
        expected_rsp_q.push_back(serve_request(kind, first_block, count));
    end
    outstanding = expected_rsp_q.size();
  end

endmodule

/* bench/tb_top.sv */
// Testbench top for the bitmap extent allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import bea_pkg::*;

  localparam int         POOL_BLOCKS = 1024;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         PHASES      = 9;
  localparam int         PHASE_ITEMS = 200;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        req_valid   = 1'b0;
  logic        req_stall;
  logic [1:0]  kind        = KIND_ALLOC;
  logic [9:0]  first_block = '0;
  logic [10:0] count       = '0;
  logic        rsp_valid;
  logic        rsp_stall   = 1'b0;
  logic        status;
  logic [9:0]  granted_block;
  int          fail_count;
  int          outstanding;
  bit          rsp_quiet   = 1'b0;
  int          stall_left  = 0;

  always #6 clk = ~clk;

  bitmap_extent_allocator #(.POOL_BLOCKS(POOL_BLOCKS)) i_dut (.*);

  extent_checker #(.POOL_BLOCKS(POOL_BLOCKS)) i_checker (.*);

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Small runs dominate so that the map fragments; a few exceed the pool or are empty.
  function automatic logic [10:0] pick_count();
    int r = $urandom_range(0, 99);
    if (r < 60) return 11'($urandom_range(1, 32));
    if (r < 85) return 11'($urandom_range(33, 300));
    if (r < 96) return 11'($urandom_range(301, POOL_BLOCKS));
    if (r < 98) return 11'($urandom_range(POOL_BLOCKS + 1, 2047));
    return '0;
  endfunction

  always @(negedge clk) begin : rsp_backpressure
    int n;
    if (rsp_quiet) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      n = pick_gap();
      rsp_stall  <= (n != 0);
      stall_left <= (n != 0) ? n - 1 : 0;
    end
  end

  task automatic send_request(logic [1:0] k, logic [9:0] fb, logic [10:0] cnt);
    @(negedge clk);
    kind        <= k;
    first_block <= fb;
    count       <= cnt;
    req_valid   <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic hold_off(int cycles);
    if (cycles == 0) return;
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stops sending until every outstanding transaction has been answered.
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int         sent;
    int         r;
    bit         fill_phase;
    logic [1:0] k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: full pool, exhaustion, clipping, empty runs and the unused kind.
    send_request(KIND_ALLOC, 10'd0, 11'd1);
    send_request(KIND_ALLOC, 10'd0, 11'd1023);
    send_request(KIND_ALLOC, 10'd0, 11'd1);
    send_request(KIND_ALLOC, 10'd1023, 11'd0);
    send_request(KIND_FREE, 10'd0, 11'd1);
    send_request(KIND_ALLOC, 10'd0, 11'd1);
    send_request(KIND_FREE, 10'd1023, 11'd2047);
    send_request(KIND_ALLOC, 10'd0, 11'd2);
    send_request(KIND_ALLOC, 10'd0, 11'd1);
    send_request(KIND_FREE, 10'd0, 11'd2047);
    send_request(KIND_ALLOC, 10'd0, 11'd1025);
    send_request(KIND_ALLOC, 10'd0, 11'd1024);
    send_request(KIND_FREE, 10'd0, 11'd1024);
    send_request(KIND_RESERVE, 10'd1023, 11'd2047);
    send_request(KIND_RESERVE, 10'd0, 11'd0);
    send_request(KIND_FREE, 10'd5, 11'd0);
    send_request(KIND_UNUSED, 10'd1023, 11'd2047);
    send_request(KIND_RESERVE, 10'd512, 11'd512);
    send_request(KIND_ALLOC, 10'd0, 11'd513);
    send_request(KIND_ALLOC, 10'd0, 11'd512);
    send_request(KIND_FREE, 10'd100, 11'd300);
    send_request(KIND_ALLOC, 10'd0, 11'd300);
    send_request(KIND_FREE, 10'd0, 11'd1024);
    drain();

    // Random phases fill the pool in every third phase, starting with the first, and churn
    // it in the others; the phases after a filling phase run with no gaps on either side.
    for (int phase = 0; phase < PHASES; phase++) begin
      rsp_quiet  <= (phase % 3 == 1);
      fill_phase = (phase % 3 == 0);
      sent       = 0;
      if (phase % 2 == 0) begin
        send_request(KIND_FREE, 10'd0, 11'd1024);
        sent++;
      end
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < (fill_phase ? 65 : 45))
          k = KIND_ALLOC;
        else if (r < 85)
          k = KIND_FREE;
        else if (r < 95)
          k = KIND_RESERVE;
        else
          k = KIND_UNUSED;
        send_request(k, 10'($urandom_range(0, POOL_BLOCKS - 1)), pick_count());
        if (k != KIND_UNUSED) sent++;
        if (phase % 3 != 1) hold_off(pick_gap());
      end
      drain();
    end

    rsp_quiet <= 1'b0;
    repeat (80) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* bitmap_extent_allocator.f */
hw/rtl/bea_pkg.sv
hw/rtl/bea_map_mem.sv
hw/rtl/bea_word_scan.sv
hw/rtl/bitmap_extent_allocator.sv
bench/extent_checker.sv
bench/tb_top.sv
